FILE: design/tcw_pkg.sv
`default_nettype none

package tcw_pkg;

  // Default screen geometry.
  localparam int COLUMNS_DEF     = 80;
  localparam int SCREEN_ROWS_DEF = 25;
  localparam int SCROLL_ROWS_DEF = 25;

  // Field widths of the request and response transactions.
  localparam int OP_W    = 3;
  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 4;
  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int CELL_W  = 2 * COLOR_W + CHAR_W;

  typedef logic [OP_W-1:0]    op_code_t;
  typedef logic [CHAR_W-1:0]  char_t;
  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [CELL_W-1:0]  cell_t;

  localparam op_code_t OP_PUT_CHAR  = 3'd0;
  localparam op_code_t OP_PUT_ENTRY = 3'd1;
  localparam op_code_t OP_SET_COLOR = 3'd2;
  localparam op_code_t OP_CLEAR     = 3'd3;
  localparam op_code_t OP_READ      = 3'd4;

  localparam char_t  NEWLINE_CHAR = 8'h0A;
  localparam char_t  BLANK_CHAR   = 8'h20;
  localparam color_t COLOR_WHITE  = 4'hF;
  localparam color_t COLOR_BLACK  = 4'h0;

  typedef struct packed {
    logic [COL_W-1:0] cursor_x;
    logic [ROW_W-1:0] cursor_y;
    char_t            read_character;
    color_t           read_foreground;
    color_t           read_background;
    logic             scrolled;
  } tcw_result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_READ
  } tcw_state_t;

  typedef enum logic {
    SWEEP_FILL,
    SWEEP_SHIFT
  } sweep_mode_t;

  typedef enum logic [1:0] {
    SRC_MEM,
    SRC_FILL,
    SRC_ZERO
  } cell_src_t;

  // Cell layout: background in the top nibble, foreground below it, then the character.
  function automatic cell_t pack_cell(input char_t ch, input color_t fg, input color_t bg);
    return {bg, fg, ch};
  endfunction

endpackage

`default_nettype wire

FILE: design/tcw_if.sv
`default_nettype none

// Request channel: one console operation per transaction.
interface tcw_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [tcw_pkg::OP_W-1:0]             operation;
  logic [tcw_pkg::CHAR_W-1:0]           character;
  logic [tcw_pkg::COLOR_W-1:0]          foreground;
  logic [tcw_pkg::COLOR_W-1:0]          background;
  logic [tcw_pkg::COL_W-1:0]            col;
  logic [tcw_pkg::ROW_W-1:0]            row;

  modport source (output valid, operation, character, foreground, background, col, row,
                  input ready);
  modport sink   (input valid, operation, character, foreground, background, col, row,
                  output ready);
endinterface

// Response channel: one result per request.
interface tcw_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic [tcw_pkg::COL_W-1:0]            cursor_x;
  logic [tcw_pkg::ROW_W-1:0]            cursor_y;
  logic [tcw_pkg::CHAR_W-1:0]           read_character;
  logic [tcw_pkg::COLOR_W-1:0]          read_foreground;
  logic [tcw_pkg::COLOR_W-1:0]          read_background;
  logic                                 scrolled;

  modport source (output valid, cursor_x, cursor_y, read_character, read_foreground,
                  read_background, scrolled,
                  input ready);
  modport sink   (input valid, cursor_x, cursor_y, read_character, read_foreground,
                  read_background, scrolled,
                  output ready);
endinterface

`default_nettype wire

FILE: design/text_console_writer_core.sv
`default_nettype none

// Text console writer: a character screen of COLUMNS x SCREEN_ROWS cells held in one
// synchronous memory with a single write port and a registered read port. Every request
// transaction yields exactly one response transaction. Put-char, put-entry, newline,
// set-colour and unused codes complete on acceptance, so a stream of ordinary characters
// runs at one transaction per cycle while the skid entry is free. A read goes on to the
// ST_READ state, which waits for the registered memory data. A put that runs past the last
// scroll row triggers a scroll, which walks min(SCROLL_ROWS, SCREEN_ROWS) x COLUMNS cells
// through the memory, one cell per cycle, and then drains; clear walks every cell. These
// passes are paced by the single memory write port. After reset the block clears the
// store to zero in a pass over all COLUMNS x SCREEN_ROWS cells (2000 with the default
// geometry), followed by the drain state, before it accepts the first request. A two-entry
// output queue lets a new request be accepted while a response is still waiting.
module text_console_writer_core #(
  parameter int COLUMNS     = tcw_pkg::COLUMNS_DEF,
  parameter int SCREEN_ROWS = tcw_pkg::SCREEN_ROWS_DEF,
  parameter int SCROLL_ROWS = tcw_pkg::SCROLL_ROWS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  tcw_req_if.sink       req,
  tcw_rsp_if.source     rsp
);
  import tcw_pkg::*;

  // Geometry derived from the parameters.
  localparam int CELL_COUNT  = COLUMNS * SCREEN_ROWS;
  localparam int ADDR_W      = $clog2(CELL_COUNT);
  localparam int CUR_COL_W   = $clog2(COLUMNS);
  localparam int CUR_LINE_W  = $clog2(SCROLL_ROWS);
  localparam int SHIFT_ROWS  = (SCROLL_ROWS < SCREEN_ROWS) ? SCROLL_ROWS : SCREEN_ROWS;
  localparam int CELL_LAST   = CELL_COUNT - 1;
  localparam int SHIFT_LAST  = SHIFT_ROWS * COLUMNS - 1;
  localparam int BLANK_START = (SCROLL_ROWS - 1) * COLUMNS;

  // Cell store.
  cell_t cells [CELL_COUNT];

  // Control and cursor state.
  tcw_state_t              state, state_next;
  logic [CUR_COL_W-1:0]    cursor_column, cursor_column_next;
  logic [CUR_LINE_W-1:0]   cursor_line, cursor_line_next;
  color_t                  cur_fg, cur_fg_next;
  color_t                  cur_bg, cur_bg_next;

  // Sweep engine used by the reset clearing pass, clear and scroll.
  logic [ADDR_W-1:0]       sweep_cnt;
  logic [ADDR_W-1:0]       sweep_last;
  sweep_mode_t             sweep_mode;
  cell_t                   fill_cell;
  logic                    sweep_report;
  logic                    pend_scrolled;
  cell_src_t               sweep_src;
  logic                    s1_valid;
  logic [ADDR_W-1:0]       s1_addr;
  cell_src_t               s1_src;

  logic                    sweep_start;
  sweep_mode_t             start_mode;
  logic [ADDR_W-1:0]       start_last;
  cell_t                   start_fill;

  // Memory ports.
  logic                    mem_we;
  logic [ADDR_W-1:0]       mem_waddr;
  cell_t                   mem_wdata;
  logic                    rd_en;
  logic [ADDR_W-1:0]       mem_raddr;
  cell_t                   rd_data;
  logic                    rd_ok;

  // Response path: output register plus one skid entry.
  tcw_result_t             res;
  logic                    res_push;
  tcw_result_t             out_q;
  logic                    out_valid;
  tcw_result_t             skid_q;
  logic                    skid_valid;

  // Request decode.
  logic                    accept;
  logic                    is_put;
  logic                    is_newline;
  logic                    at_last_col;
  logic                    at_last_line;
  logic                    advance;
  logic                    scroll_now;
  logic                    line_in_store;
  logic [ADDR_W-1:0]       cursor_addr;
  logic                    rd_in_range;
  logic [ADDR_W-1:0]       rd_in_addr;
  color_t                  put_fg, put_bg;

  // A request is taken only between passes and only while the skid entry is free, so
  // its response always has a place to go.
  assign req.ready = (state == ST_IDLE) && !skid_valid;
  assign accept    = req.valid && req.ready;

  assign is_put       = (req.operation == OP_PUT_CHAR) || (req.operation == OP_PUT_ENTRY);
  assign is_newline   = (req.character == NEWLINE_CHAR);
  assign at_last_col  = (cursor_column == CUR_COL_W'(COLUMNS - 1));
  assign at_last_line = (cursor_line == CUR_LINE_W'(SCROLL_ROWS - 1));
  assign advance      = is_newline || at_last_col;
  assign scroll_now   = accept && is_put && advance && at_last_line;
  assign put_fg       = (req.operation == OP_PUT_ENTRY) ? req.foreground : cur_fg;
  assign put_bg       = (req.operation == OP_PUT_ENTRY) ? req.background : cur_bg;

  // The cursor may sit on a scroll row beyond the store; writes there are dropped.
  assign line_in_store = (32'(cursor_line) < SCREEN_ROWS);
  assign cursor_addr   = ADDR_W'(32'(cursor_line) * COLUMNS + 32'(cursor_column));
  assign rd_in_range   = (32'(req.col) < COLUMNS) && (32'(req.row) < SCREEN_ROWS);
  assign rd_in_addr    = ADDR_W'(32'(req.row) * COLUMNS + 32'(req.col));

  // Where the cell written at the current sweep position comes from. When shifting,
  // the last scroll row is refilled with blanks, and a row whose lower neighbour lies
  // outside the store receives zeros.
  always_comb begin
    if (sweep_mode == SWEEP_FILL) begin
      sweep_src = SRC_FILL;
    end else if (32'(sweep_cnt) >= BLANK_START) begin
      sweep_src = SRC_FILL;
    end else if (32'(sweep_cnt) + COLUMNS >= CELL_COUNT) begin
      sweep_src = SRC_ZERO;
    end else begin
      sweep_src = SRC_MEM;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (scroll_now || (req.operation == OP_CLEAR)) begin
            state_next = ST_SWEEP;
          end else if (req.operation == OP_READ) begin
            state_next = ST_READ;
          end
        end
      end
      ST_SWEEP: begin
        if (sweep_cnt == sweep_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_IDLE;
      ST_READ:  state_next = ST_IDLE;
    endcase
  end

  // Datapath control, memory ports and the response of this cycle.
  always_comb begin
    cursor_column_next = cursor_column;
    cursor_line_next   = cursor_line;
    cur_fg_next        = cur_fg;
    cur_bg_next        = cur_bg;
    sweep_start        = 1'b0;
    start_mode         = SWEEP_FILL;
    start_last         = ADDR_W'(CELL_LAST);
    start_fill         = '0;
    rd_en              = 1'b0;
    mem_raddr          = '0;
    res_push           = 1'b0;
    res                = '0;

    // The write stage of the sweep owns the write port; it is never busy in idle.
    mem_we    = s1_valid;
    mem_waddr = s1_addr;
    unique case (s1_src)
      SRC_MEM:  mem_wdata = rd_data;
      SRC_FILL: mem_wdata = fill_cell;
      SRC_ZERO: mem_wdata = '0;
      default:  mem_wdata = '0;
    endcase

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (req.operation)
            OP_PUT_CHAR, OP_PUT_ENTRY: begin
              if (!is_newline) begin
                mem_we             = line_in_store;
                mem_waddr          = cursor_addr;
                mem_wdata          = pack_cell(req.character, put_fg, put_bg);
                cursor_column_next = cursor_column + CUR_COL_W'(1);
              end
              if (advance) begin
                cursor_column_next = '0;
                if (at_last_line) begin
                  sweep_start = 1'b1;
                  start_mode  = SWEEP_SHIFT;
                  start_last  = ADDR_W'(SHIFT_LAST);
                  start_fill  = pack_cell(BLANK_CHAR, cur_fg, cur_bg);
                end else begin
                  cursor_line_next = cursor_line + CUR_LINE_W'(1);
                end
              end
              res_push = !(advance && at_last_line);
            end
            OP_SET_COLOR: begin
              cur_fg_next = req.foreground;
              cur_bg_next = req.background;
              res_push    = 1'b1;
            end
            OP_CLEAR: begin
              cursor_column_next = '0;
              cursor_line_next   = '0;
              cur_fg_next        = COLOR_WHITE;
              cur_bg_next        = req.background;
              sweep_start        = 1'b1;
              start_mode         = SWEEP_FILL;
              start_last         = ADDR_W'(CELL_LAST);
              start_fill         = pack_cell(BLANK_CHAR, COLOR_WHITE, req.background);
            end
            OP_READ: begin
              rd_en     = rd_in_range;
              mem_raddr = rd_in_addr;
            end
            default: begin
              res_push = 1'b1;
            end
          endcase
        end
      end
      ST_SWEEP: begin
        rd_en     = (sweep_src == SRC_MEM);
        mem_raddr = ADDR_W'(32'(sweep_cnt) + COLUMNS);
      end
      ST_DRAIN: begin
        res_push     = sweep_report;
        res.scrolled = pend_scrolled;
      end
      ST_READ: begin
        res_push = 1'b1;
        if (rd_ok) begin
          res.read_character  = rd_data[CHAR_W-1:0];
          res.read_foreground = rd_data[CHAR_W +: COLOR_W];
          res.read_background = rd_data[CHAR_W+COLOR_W +: COLOR_W];
        end
      end
    endcase

    res.cursor_x = COL_W'(cursor_column_next);
    res.cursor_y = ROW_W'(cursor_line_next);
  end

  // Cell store: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      cells[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= cells[mem_raddr];
    end
  end

  // Control registers. Reset starts the zeroing pass over the whole store.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_SWEEP;
      cursor_column <= '0;
      cursor_line   <= '0;
      cur_fg        <= COLOR_WHITE;
      cur_bg        <= COLOR_BLACK;
      sweep_cnt     <= '0;
      sweep_last    <= ADDR_W'(CELL_LAST);
      sweep_mode    <= SWEEP_FILL;
      fill_cell     <= '0;
      sweep_report  <= 1'b0;
      pend_scrolled <= 1'b0;
      s1_valid      <= 1'b0;
      rd_ok         <= 1'b0;
    end else begin
      state         <= state_next;
      cursor_column <= cursor_column_next;
      cursor_line   <= cursor_line_next;
      cur_fg        <= cur_fg_next;
      cur_bg        <= cur_bg_next;
      if (sweep_start) begin
        sweep_cnt     <= '0;
        sweep_last    <= start_last;
        sweep_mode    <= start_mode;
        fill_cell     <= start_fill;
        sweep_report  <= 1'b1;
        pend_scrolled <= (start_mode == SWEEP_SHIFT);
      end else if (state == ST_SWEEP) begin
        sweep_cnt <= sweep_cnt + ADDR_W'(1);
      end
      s1_valid <= (state == ST_SWEEP);
      rd_ok    <= rd_en;
    end
  end

  // The write stage follows the read issue in the next cycle, matching the registered read port.
  always_ff @(posedge clk) begin
    s1_addr <= sweep_cnt;
    s1_src  <= sweep_src;
  end

  // Output queue: the register that drives the port, backed by one skid entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !rsp.ready) begin
      if (res_push) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= res_push;
    end else begin
      out_valid <= res_push;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !rsp.ready) begin
      if (res_push) begin
        skid_q <= res;
      end
    end else if (skid_valid) begin
      out_q  <= skid_q;
      skid_q <= res;
    end else begin
      out_q <= res;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.cursor_x        = out_q.cursor_x;
  assign rsp.cursor_y        = out_q.cursor_y;
  assign rsp.read_character  = out_q.read_character;
  assign rsp.read_foreground = out_q.read_foreground;
  assign rsp.read_background = out_q.read_background;
  assign rsp.scrolled        = out_q.scrolled;

  // A response is never produced while both queue entries are held.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !rsp.ready && skid_valid) |-> !res_push)
    else $error("response queue overflow");

  // Every write lands inside the store.
  assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (32'(mem_waddr) < CELL_COUNT))
    else $error("cell write outside the store");

  // The sweep write stage only follows a cycle of sweep issue.
  assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> ($past(state) == ST_SWEEP))
    else $error("sweep write without a preceding issue");

  // A scroll leaves the cursor at the start of the last scroll row.
  assert property (@(posedge clk) disable iff (rst)
    (res_push && res.scrolled) |->
      (cursor_column_next == '0) && (cursor_line_next == CUR_LINE_W'(SCROLL_ROWS - 1)))
    else $error("cursor misplaced after scroll");

endmodule

`default_nettype wire
